// File: src/stt_pkg.sv
`default_nettype none

package stt_pkg;

  // input item kinds
  localparam logic KIND_PUT  = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  // memory port controls
  typedef struct packed {
    logic we;
    logic re;
  } mem_ctl_t;

  // load request for the result register
  typedef struct packed {
    logic load;
    logic refused;
    logic last;
  } res_ctl_t;

endpackage

`default_nettype wire

// File: src/stt_mem.sv
`default_nettype none

module stt_mem #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 24
) (
  input  wire logic                     clk_i,
  input  wire stt_pkg::mem_ctl_t        ctl_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // read data only changes on a read, so a stalled sweep keeps its entry
  always_ff @(posedge clk_i) begin
    if (ctl_i.we) begin
      mem[waddr_i] <= wdata_i;
    end
    if (ctl_i.re) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// File: src/stt_out.sv
`default_nettype none

module stt_out #(
  parameter int ID_BITS = 8
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire stt_pkg::res_ctl_t  ctl_i,
  input  wire logic [ID_BITS-1:0] woken_i,
  output logic                    free_o,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic      [ID_BITS-1:0] woken_thread_o,
  output logic                    put_refused_o,
  output logic                    last_o
);

  logic               valid_q, valid_d;
  logic [ID_BITS-1:0] woken_q;
  logic               refused_q;
  logic               last_q;

  assign free_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (out_ready_i) begin
      valid_d = 1'b0;
    end
    if (ctl_i.load) begin
      valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      woken_q   <= woken_i;
      refused_q <= ctl_i.refused;
      last_q    <= ctl_i.last;
    end
  end

  assign out_valid_o    = valid_q;
  assign woken_thread_o = woken_q;
  assign put_refused_o  = refused_q;
  assign last_o         = last_q;

endmodule

`default_nettype wire

// File: src/sleep_timer_table_unit.sv
`default_nettype none
// sleep timer table: threads sleeping in insertion order, counted down by ticks
// input channel (in_valid_i / in_ready_o) carries one item: kind_i selects a
// put of thread_id_i for sleep_ticks_i ticks (zero acts as one) or a timer tick
// output channel (out_valid_o / out_ready_i) carries result items
// a put gives one result the cycle after it is taken: put_refused_o set when
// all CAPACITY slots are in use, last_o set
// a tick sweeps the table memory one entry per cycle while no stall holds it
// (read, decrement, write back packed); every thread whose count runs out
// gives one result in insertion order, last_o on the final one, and a tick
// that wakes nothing gives no result
// new items are taken only between sweeps and while the result register is
// free or draining
// a receiver stall holds the sweep on a woken entry until the result register
// drains; results are never dropped
// reset empties the table at once (occupancy cleared, no clearing pass) and
// clears the output valid flag; slot contents need no reset
module sleep_timer_table_unit #(
  parameter int CAPACITY  = 16,
  parameter int ID_BITS   = 8,
  parameter int TIME_BITS = 16
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire logic                 kind_i,
  input  wire logic [ID_BITS-1:0]   thread_id_i,
  input  wire logic [TIME_BITS-1:0] sleep_ticks_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output logic      [ID_BITS-1:0]   woken_thread_o,
  output logic                      put_refused_o,
  output logic                      last_o
);

  localparam int AW = $clog2(CAPACITY);
  localparam int OW = $clog2(CAPACITY + 1);
  localparam int EW = ID_BITS + TIME_BITS;

  localparam logic ST_IDLE  = 1'b0;
  localparam logic ST_SWEEP = 1'b1;

  logic               state_q, state_d;
  logic [OW-1:0]      occ_q, occ_d;
  logic [OW-1:0]      idx_q, idx_d;
  logic [OW-1:0]      keep_q, keep_d;
  logic               rd_valid_q, rd_valid_d;
  logic               pend_valid_q, pend_valid_d;
  logic [ID_BITS-1:0] pend_thread_q, pend_thread_d;

  stt_pkg::mem_ctl_t  mem_ctl;
  logic [AW-1:0]      waddr;
  logic [EW-1:0]      wdata;
  logic [EW-1:0]      rdata;
  logic [ID_BITS-1:0] rd_thread;
  logic [TIME_BITS-1:0] rd_rem;

  stt_pkg::res_ctl_t  res_ctl;
  logic [ID_BITS-1:0] res_woken;
  logic               out_free;

  logic in_acc;
  logic woken;
  logic stall;

  assign rd_thread = rdata[EW-1:TIME_BITS];
  assign rd_rem    = rdata[TIME_BITS-1:0];

  assign in_ready_o = (state_q == ST_IDLE) && out_free;
  assign in_acc     = in_valid_i && in_ready_o;
  assign woken      = rd_valid_q && (rd_rem <= TIME_BITS'(1));
  // a second woken entry needs the pending one pushed out first
  assign stall      = woken && pend_valid_q && !out_free;

  always_comb begin
    state_d       = state_q;
    occ_d         = occ_q;
    idx_d         = idx_q;
    keep_d        = keep_q;
    rd_valid_d    = rd_valid_q;
    pend_valid_d  = pend_valid_q;
    pend_thread_d = pend_thread_q;
    mem_ctl       = '0;
    waddr         = keep_q[AW-1:0];
    wdata         = {rd_thread, rd_rem - TIME_BITS'(1)};
    res_ctl       = '0;
    res_woken     = pend_thread_q;

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (kind_i == stt_pkg::KIND_PUT) begin
            res_woken    = '0;
            res_ctl.load = 1'b1;
            res_ctl.last = 1'b1;
            if (occ_q == OW'(CAPACITY)) begin
              res_ctl.refused = 1'b1;
            end else begin
              mem_ctl.we = 1'b1;
              waddr      = occ_q[AW-1:0];
              wdata      = {thread_id_i,
                            (sleep_ticks_i == '0) ? TIME_BITS'(1) : sleep_ticks_i};
              occ_d      = occ_q + OW'(1);
            end
          end else begin
            idx_d        = '0;
            keep_d       = '0;
            rd_valid_d   = 1'b0;
            pend_valid_d = 1'b0;
            state_d      = ST_SWEEP;
          end
        end
      end
      ST_SWEEP: begin
        if (!stall) begin
          if (rd_valid_q) begin
            if (woken) begin
              if (pend_valid_q) begin
                res_ctl.load = 1'b1;
              end
              pend_valid_d  = 1'b1;
              pend_thread_d = rd_thread;
            end else begin
              // survivors pack down toward slot zero
              mem_ctl.we = 1'b1;
              keep_d     = keep_q + OW'(1);
            end
          end
          if (idx_q < occ_q) begin
            mem_ctl.re = 1'b1;
            idx_d      = idx_q + OW'(1);
            rd_valid_d = 1'b1;
          end else begin
            rd_valid_d = 1'b0;
          end
          if (!rd_valid_q && (idx_q == occ_q)) begin
            if (!pend_valid_q) begin
              occ_d   = keep_q;
              state_d = ST_IDLE;
            end else if (out_free) begin
              res_ctl.load = 1'b1;
              res_ctl.last = 1'b1;
              pend_valid_d = 1'b0;
              occ_d        = keep_q;
              state_d      = ST_IDLE;
            end
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      occ_q        <= '0;
      idx_q        <= '0;
      keep_q       <= '0;
      rd_valid_q   <= 1'b0;
      pend_valid_q <= 1'b0;
    end else begin
      state_q      <= state_d;
      occ_q        <= occ_d;
      idx_q        <= idx_d;
      keep_q       <= keep_d;
      rd_valid_q   <= rd_valid_d;
      pend_valid_q <= pend_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_thread_q <= pend_thread_d;
  end

  stt_mem #(
    .DEPTH (CAPACITY),
    .WIDTH (EW)
  ) u_mem (
    .clk_i   (clk_i),
    .ctl_i   (mem_ctl),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (idx_q[AW-1:0]),
    .rdata_o (rdata)
  );

  stt_out #(
    .ID_BITS (ID_BITS)
  ) u_out (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ctl_i          (res_ctl),
    .woken_i        (res_woken),
    .free_o         (out_free),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .woken_thread_o (woken_thread_o),
    .put_refused_o  (put_refused_o),
    .last_o         (last_o)
  );

  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= OW'(CAPACITY))
    else $error("occupancy above capacity");

  a_keep_behind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SWEEP) |-> (keep_q <= idx_q && idx_q <= occ_q))
    else $error("sweep write index passed read index");

  a_refuse_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && kind_i == stt_pkg::KIND_PUT && occ_q == OW'(CAPACITY))
      |=> (out_valid_o && put_refused_o && last_o))
    else $error("put into full table not refused");

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_ctl.load |-> out_free)
    else $error("result register overwritten");

endmodule

`default_nettype wire

// File: sim/testbench.sv
`timescale 1ns / 100ps

module testbench;

  localparam int CAPACITY     = 16;
  localparam int ID_BITS      = 8;
  localparam int TIME_BITS    = 16;
  localparam int RANDOM_ITEMS = 200;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 40;
  localparam int MAX_REPORTS  = 10;

  typedef struct packed {
    logic [ID_BITS-1:0] woken;
    logic               refused;
    logic               last;
  } wake_result_t;

  // mirror of the sleep table; each accepted item queues the results it causes
  class wake_scoreboard;
    logic [ID_BITS-1:0]   slot_thread [CAPACITY];
    logic [TIME_BITS-1:0] slot_left   [CAPACITY];
    int                   occupancy;
    wake_result_t         pending[$];
    int                   failures;
    int                   puts;
    int                   refusals;
    int                   ticks;
    int                   woken;

    function new();
      occupancy = 0;
      failures  = 0;
      puts      = 0;
      refusals  = 0;
      ticks     = 0;
      woken     = 0;
    endfunction

    function void note_item(logic kind, logic [ID_BITS-1:0] tid,
                            logic [TIME_BITS-1:0] sleep);
      wake_result_t wakes[$];
      wake_result_t res;
      int           keep;
      if (kind == stt_pkg::KIND_PUT) begin
        puts++;
        res = '{woken: '0, refused: 1'b0, last: 1'b1};
        if (occupancy >= CAPACITY) begin
          refusals++;
          res.refused = 1'b1;
        end else begin
          slot_thread[occupancy] = tid;
          slot_left[occupancy]   = (sleep == '0) ? TIME_BITS'(1) : sleep;
          occupancy++;
        end
        pending.push_back(res);
      end else begin
        ticks++;
        keep = 0;
        for (int i = 0; i < occupancy; i++) begin
          if (slot_left[i] <= 1) begin
            res = '{woken: slot_thread[i], refused: 1'b0, last: 1'b0};
            wakes.push_back(res);
          end else begin
            slot_thread[keep] = slot_thread[i];
            slot_left[keep]   = slot_left[i] - 1'b1;
            keep++;
          end
        end
        occupancy = keep;
        woken += wakes.size();
        for (int i = 0; i < wakes.size(); i++) begin
          res = wakes[i];
          res.last = (i == wakes.size() - 1);
          pending.push_back(res);
        end
      end
    endfunction

    function void check_result(logic [ID_BITS-1:0] woken_thread, logic refused,
                               logic last);
      wake_result_t exp;
      if (pending.size() == 0) begin
        failures++;
        if (failures <= MAX_REPORTS)
          $display("%0t: unexpected result woken=%0d refused=%0b last=%0b",
                   $realtime, woken_thread, refused, last);
      end else begin
        exp = pending.pop_front();
        if (woken_thread !== exp.woken || refused !== exp.refused ||
            last !== exp.last) begin
          failures++;
          if (failures <= MAX_REPORTS)
            $display("%0t: mismatch woken/refused/last exp %0d/%0b/%0b got %0d/%0b/%0b",
                     $realtime, exp.woken, exp.refused, exp.last,
                     woken_thread, refused, last);
        end
      end
    endfunction
  endclass

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 in_valid_i;
  logic                 in_ready_o;
  logic                 kind_i;
  logic [ID_BITS-1:0]   thread_id_i;
  logic [TIME_BITS-1:0] sleep_ticks_i;
  logic                 out_valid_o;
  logic                 out_ready_i;
  logic [ID_BITS-1:0]   woken_thread_o;
  logic                 put_refused_o;
  logic                 last_o;

  wake_scoreboard sb;
  logic           hold_off_req = 1'b0;
  int             calm_left = 0;

  sleep_timer_table_unit #(
    .CAPACITY (CAPACITY),
    .ID_BITS  (ID_BITS),
    .TIME_BITS(TIME_BITS)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .kind_i        (kind_i),
    .thread_id_i   (thread_id_i),
    .sleep_ticks_i (sleep_ticks_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .woken_thread_o(woken_thread_o),
    .put_refused_o (put_refused_o),
    .last_o        (last_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // sender idle length: mostly none or short, a few long, with calm stretches
  function automatic int sender_gap();
    int r;
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 5) begin
      calm_left = $urandom_range(15, 40);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_item(input logic kind, input logic [ID_BITS-1:0] tid,
                           input logic [TIME_BITS-1:0] sleep);
    int gap;
    gap = sender_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    kind_i        <= kind;
    thread_id_i   <= tid;
    sleep_ticks_i <= sleep;
    do @(posedge clk_i); while (in_ready_o !== 1'b1);
    sb.note_item(kind, tid, sleep);
  endtask

  task automatic put_thread(input logic [ID_BITS-1:0] tid,
                            input logic [TIME_BITS-1:0] sleep);
    send_item(stt_pkg::KIND_PUT, tid, sleep);
  endtask

  task automatic tick();
    send_item(stt_pkg::KIND_TICK, ID_BITS'($urandom_range(0, 255)),
              TIME_BITS'($urandom_range(0, 65535)));
  endtask

  // receiver: bursts of ready with short or long stalls, one long hold-off on request
  initial begin : receiver
    int run_left;
    int hold_left;
    int r;
    run_left  = 0;
    hold_left = 0;
    out_ready_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        hold_left    = HOLD_CYCLES;
        run_left     = 1;
      end
      if (hold_left == 0 && run_left == 0) begin
        r = $urandom_range(0, 99);
        if (r < 10) begin
          run_left = $urandom_range(50, 150);
        end else begin
          run_left = $urandom_range(1, 12);
          r = $urandom_range(0, 99);
          if (r < 60) hold_left = $urandom_range(1, 3);
          else if (r < 90) hold_left = 0;
          else hold_left = $urandom_range(10, 40);
        end
      end
      if (hold_left > 0) begin
        out_ready_i <= 1'b0;
        hold_left--;
      end else begin
        out_ready_i <= 1'b1;
        run_left--;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o === 1'b1 && out_ready_i === 1'b1)
      sb.check_result(woken_thread_o, put_refused_o, last_o);
  end

  initial begin : main
    logic kind;
    int   tick_pct;
    int   r;
    logic [TIME_BITS-1:0] sleep;
    sb = new();
    rst_ni        <= 1'b0;
    in_valid_i    <= 1'b0;
    kind_i        <= stt_pkg::KIND_PUT;
    thread_id_i   <= '0;
    sleep_ticks_i <= '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty tick, field extremes, zero sleep, multi-wake, full table
    tick();
    put_thread(8'd0, 16'd0);
    put_thread(8'd255, 16'hFFFF);
    put_thread(8'h5A, 16'd1);
    put_thread(8'hA5, 16'd2);
    tick();
    tick();
    tick();
    for (int i = 1; i < CAPACITY; i++)
      put_thread(ID_BITS'(i), 16'd1);
    put_thread(8'h77, 16'd3);
    tick();

    // random: mixed traffic with periodic fill phases that push into refusals
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == 100) hold_off_req = 1'b1;
      if (((n / 20) % 4) == 1) tick_pct = 5;
      else tick_pct = 35;
      kind = ($urandom_range(0, 99) < tick_pct) ? stt_pkg::KIND_TICK : stt_pkg::KIND_PUT;
      if (kind == stt_pkg::KIND_TICK) begin
        tick();
      end else begin
        r = $urandom_range(0, 99);
        if (r < 10) sleep = '0;
        else if (r < 80) sleep = TIME_BITS'($urandom_range(1, 4));
        else if (r < 97) sleep = TIME_BITS'($urandom_range(5, 24));
        else sleep = TIME_BITS'($urandom_range(0, 65535));
        put_thread(ID_BITS'($urandom_range(0, 255)), sleep);
      end
    end
    in_valid_i <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("covered %0d puts (%0d refused) and %0d ticks, %0d threads woken",
             sb.puts, sb.refusals, sb.ticks, sb.woken);
    $display("%0d result failures", sb.failures);
    if (sb.failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin : watchdog
    #5000000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
